FILE: src/tprs_pkg.sv
package tprs_pkg;

    localparam int CMD_W    = 2;
    localparam int HANDLE_W = 6;
    localparam int PRIO_W   = 4;
    localparam int STATUS_W = 3;

    localparam logic [PRIO_W-1:0] CAP_INIT  = 4'd2;
    localparam logic [PRIO_W-1:0] STEP_INIT = 4'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_PROMOTE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED    = 3'd0,
        ST_POPPED    = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_PROMOTED  = 3'd3,
        ST_NO_CHANGE = 3'd4,
        ST_REJECTED  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_SCAN,
        S_POP1,
        S_POP2,
        S_PRO_W,
        S_PRO_A,
        S_EMIT
    } t_state;

endpackage

FILE: src/tprs_in_if.sv
interface tprs_in_if import tprs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   priority_req;

    modport source (output valid, cmd, handle, priority_req, input ready);
    modport sink (input valid, cmd, handle, priority_req, output ready);
endinterface

FILE: src/tprs_out_if.sv
interface tprs_out_if import tprs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_handle;
    logic [PRIO_W-1:0]   out_priority;

    modport source (output valid, status, out_handle, out_priority, input ready);
    modport sink (input valid, status, out_handle, out_priority, output ready);
endinterface

FILE: src/tprs_ram.sv
module tprs_ram #(
    parameter int DW    = 6,
    parameter int AW    = 6,
    parameter int DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/tprs_cycler.sv
module tprs_cycler import tprs_pkg::*; #(
    parameter int NUM_PRIORITIES = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    output logic [PRIO_W-1:0] o_step
);
    logic [PRIO_W-1:0] r_cap, n_cap, r_step, n_step;

    always_comb begin
        n_cap  = r_cap;
        n_step = r_step;
        if (i_advance) begin
            if (r_step >= r_cap) begin
                n_step = STEP_INIT;
                n_cap  = (r_cap >= PRIO_W'(NUM_PRIORITIES)) ? CAP_INIT : r_cap + 1'b1;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_INIT;
            r_step <= STEP_INIT;
        end else begin
            r_cap  <= n_cap;
            r_step <= n_step;
        end
    end

    assign o_step = r_step;
endmodule

FILE: src/triangular_priority_ready_scheduler.sv
// Channel  Dir  Fields
// i_req    in   cmd, handle, priority_req
// o_res    out  status, out_handle, out_priority
//
// A push, or a promote that cannot move, passes S_CHK and S_EMIT; a promote that moves
// also passes S_PRO_W and S_PRO_A. A pop scans empty levels in S_SCAN, then passes
// S_POP1 and S_POP2, or goes to S_EMIT if none is ready. Command 3 gives no result.
// A result is held in an output register, and a new request is taken while it waits.
// Reset clears the list lengths, the ready flags and the cycler.
module triangular_priority_ready_scheduler import tprs_pkg::*; #(
    parameter int NUM_PRIORITIES = 10,
    parameter int NUM_HANDLES    = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tprs_in_if.sink    i_req,
    tprs_out_if.source o_res
);
    localparam int HW = $clog2(NUM_HANDLES);
    localparam int LW = $clog2(NUM_PRIORITIES);
    localparam int CW = $clog2(NUM_HANDLES + 1);
    localparam int SAW = LW + HW;

    t_state r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [HANDLE_W-1:0] r_h, n_h, r_got, n_got;
    logic [PRIO_W-1:0]   r_pr, n_pr, r_lv, n_lv;
    logic [HW-1:0]       r_slot, n_slot;
    logic [CW-1:0]       r_len [NUM_PRIORITIES];
    logic [CW-1:0]       n_len [NUM_PRIORITIES];
    logic [NUM_HANDLES-1:0] r_ready, n_ready, r_known, n_known;
    logic [STATUS_W-1:0] r_rst_st, n_rst_st;
    logic [HANDLE_W-1:0] r_rh, n_rh;
    logic [PRIO_W-1:0]   r_rp, n_rp;
    logic                r_ov;
    logic [STATUS_W-1:0] r_ost;
    logic [HANDLE_W-1:0] r_oh;
    logic [PRIO_W-1:0]   r_op;

    logic accept, any_ready, advance;
    logic [PRIO_W-1:0] step, cur_lv, clamp;
    logic [HW-1:0] hidx;
    logic [LW-1:0] li;
    logic [CW-1:0] len_sel;

    logic          st_we, st_re, sl_we, sl_re, lv_we, lv_re;
    logic [SAW-1:0] st_waddr, st_raddr;
    logic [HANDLE_W-1:0] st_wdata, st_rdata;
    logic [HW-1:0] sl_waddr, sl_raddr, sl_wdata, sl_rdata;
    logic [HW-1:0] lv_waddr, lv_raddr;
    logic [PRIO_W-1:0] lv_wdata, lv_rdata;

    tprs_ram #(.DW(HANDLE_W), .AW(SAW), .DEPTH(NUM_PRIORITIES * (2 ** HW))) u_store (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_re(st_re), .i_raddr(st_raddr), .o_rdata(st_rdata)
    );
    tprs_ram #(.DW(HW), .AW(HW), .DEPTH(NUM_HANDLES)) u_slot (
        .i_clk(i_clk), .i_we(sl_we), .i_waddr(sl_waddr), .i_wdata(sl_wdata),
        .i_re(sl_re), .i_raddr(sl_raddr), .o_rdata(sl_rdata)
    );
    tprs_ram #(.DW(PRIO_W), .AW(HW), .DEPTH(NUM_HANDLES)) u_level (
        .i_clk(i_clk), .i_we(lv_we), .i_waddr(lv_waddr), .i_wdata(lv_wdata),
        .i_re(lv_re), .i_raddr(lv_raddr), .o_rdata(lv_rdata)
    );
    tprs_cycler #(.NUM_PRIORITIES(NUM_PRIORITIES)) u_cycler (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_advance(advance), .o_step(step)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign hidx        = HW'(r_h);
    assign cur_lv      = r_known[hidx] ? lv_rdata : '0;

    always_comb begin
        any_ready = 1'b0;
        for (int k = 0; k < NUM_PRIORITIES; k++) begin
            any_ready = any_ready | (r_len[k] != '0);
        end
    end

    always_comb begin
        clamp = r_pr;
        if (r_pr < PRIO_W'(1)) begin
            clamp = PRIO_W'(1);
        end
        if (r_pr > PRIO_W'(NUM_PRIORITIES)) begin
            clamp = PRIO_W'(NUM_PRIORITIES);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_h      = r_h;
        n_got    = r_got;
        n_pr     = r_pr;
        n_lv     = r_lv;
        n_slot   = r_slot;
        n_len    = r_len;
        n_ready  = r_ready;
        n_known  = r_known;
        n_rst_st = r_rst_st;
        n_rh     = r_rh;
        n_rp     = r_rp;
        advance  = 1'b0;
        li       = '0;
        st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_re = 1'b0; st_raddr = '0;
        sl_we = 1'b0; sl_waddr = '0; sl_wdata = '0;
        sl_re = accept; sl_raddr = HW'(i_req.handle);
        lv_we = 1'b0; lv_waddr = '0; lv_wdata = '0;
        lv_re = accept; lv_raddr = HW'(i_req.handle);
        len_sel = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd = i_req.cmd;
                    n_h   = i_req.handle;
                    n_pr  = i_req.priority_req;
                    case (t_cmd'(i_req.cmd))
                        CMD_PUSH, CMD_PROMOTE: n_state = S_CHK;
                        CMD_POP:               n_state = S_SCAN;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_CHK: begin
                n_rh    = r_h;
                n_state = S_EMIT;
                if (32'(r_h) >= NUM_HANDLES) begin
                    n_rst_st = (r_cmd == CMD_PUSH) ? ST_REJECTED : ST_NO_CHANGE;
                    n_rp     = '0;
                end else if (r_cmd == CMD_PUSH) begin
                    if (r_ready[hidx]) begin
                        n_rst_st = ST_REJECTED;
                        n_rp     = cur_lv;
                    end else begin
                        li        = LW'(clamp - 1'b1);
                        len_sel   = r_len[li];
                        st_we     = 1'b1;
                        st_waddr  = {li, HW'(len_sel)};
                        st_wdata  = r_h;
                        sl_we     = 1'b1;
                        sl_waddr  = hidx;
                        sl_wdata  = HW'(len_sel);
                        lv_we     = 1'b1;
                        lv_waddr  = hidx;
                        lv_wdata  = clamp;
                        n_len[li] = len_sel + 1'b1;
                        n_ready[hidx] = 1'b1;
                        n_known[hidx] = 1'b1;
                        n_rst_st  = ST_PUSHED;
                        n_rp      = clamp;
                    end
                end else begin
                    n_rp     = cur_lv;
                    n_rst_st = ST_NO_CHANGE;
                    li       = LW'(cur_lv - 1'b1);
                    len_sel  = r_len[li];
                    if (r_ready[hidx] && cur_lv > PRIO_W'(1)
                        && cur_lv <= PRIO_W'(NUM_PRIORITIES)
                        && CW'(sl_rdata) < len_sel) begin
                        n_lv     = cur_lv;
                        n_slot   = sl_rdata;
                        st_re    = 1'b1;
                        st_raddr = {li, HW'(len_sel - 1'b1)};
                        n_state  = S_PRO_W;
                    end
                end
            end
            S_PRO_W: begin
                li       = LW'(r_lv - 1'b1);
                len_sel  = r_len[li] - 1'b1;
                if (r_slot != HW'(len_sel)) begin
                    st_we    = 1'b1;
                    st_waddr = {li, r_slot};
                    st_wdata = st_rdata;
                    sl_we    = 1'b1;
                    sl_waddr = HW'(st_rdata);
                    sl_wdata = r_slot;
                end
                n_len[li] = len_sel;
                n_lv      = r_lv - 1'b1;
                n_state   = S_PRO_A;
            end
            S_PRO_A: begin
                li        = LW'(r_lv - 1'b1);
                len_sel   = r_len[li];
                st_we     = 1'b1;
                st_waddr  = {li, HW'(len_sel)};
                st_wdata  = r_h;
                sl_we     = 1'b1;
                sl_waddr  = hidx;
                sl_wdata  = HW'(len_sel);
                lv_we     = 1'b1;
                lv_waddr  = hidx;
                lv_wdata  = r_lv;
                n_len[li] = len_sel + 1'b1;
                n_rst_st  = ST_PROMOTED;
                n_rh      = r_h;
                n_rp      = r_lv;
                n_state   = S_EMIT;
            end
            S_SCAN: begin
                if (!any_ready) begin
                    n_rst_st = ST_EMPTY;
                    n_rh     = '0;
                    n_rp     = '0;
                    n_state  = S_EMIT;
                end else begin
                    advance = 1'b1;
                    li      = LW'(step - 1'b1);
                    if (r_len[li] != '0) begin
                        n_lv     = step;
                        st_re    = 1'b1;
                        st_raddr = {li, HW'(0)};
                        n_state  = S_POP1;
                    end
                end
            end
            S_POP1: begin
                li       = LW'(r_lv - 1'b1);
                len_sel  = r_len[li] - 1'b1;
                n_got    = st_rdata;
                st_re    = 1'b1;
                st_raddr = {li, HW'(len_sel)};
                n_state  = S_POP2;
            end
            S_POP2: begin
                li      = LW'(r_lv - 1'b1);
                len_sel = r_len[li] - 1'b1;
                if (len_sel != '0) begin
                    st_we    = 1'b1;
                    st_waddr = {li, HW'(0)};
                    st_wdata = st_rdata;
                    sl_we    = 1'b1;
                    sl_waddr = HW'(st_rdata);
                    sl_wdata = '0;
                end
                n_len[li] = len_sel;
                n_ready[HW'(r_got)] = 1'b0;
                n_rst_st = ST_POPPED;
                n_rh     = r_got;
                n_rp     = r_lv;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ov || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= '0;
            r_known <= '0;
            r_ov    <= 1'b0;
            for (int k = 0; k < NUM_PRIORITIES; k++) begin
                r_len[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_known <= n_known;
            r_len   <= n_len;
            if (r_state == S_EMIT && (!r_ov || o_res.ready)) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_h      <= n_h;
        r_got    <= n_got;
        r_pr     <= n_pr;
        r_lv     <= n_lv;
        r_slot   <= n_slot;
        r_rst_st <= n_rst_st;
        r_rh     <= n_rh;
        r_rp     <= n_rp;
        if (r_state == S_EMIT && (!r_ov || o_res.ready)) begin
            r_ost <= r_rst_st;
            r_oh  <= r_rh;
            r_op  <= r_rp;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.status       = r_ost;
    assign o_res.out_handle   = r_oh;
    assign o_res.out_priority = r_op;
endmodule

FILE: verif/tb.sv
module tb;
    import tprs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPRIO = 10;
    localparam int NHAND = 64;
    localparam int PERIOD_VISITS = (NPRIO * (NPRIO + 1)) / 2 - 1;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] hnd;
        logic [PRIO_W-1:0]   prio;
    } t_outcome;

    class sched_scoreboard;
        logic [HANDLE_W-1:0] lists [NPRIO][NHAND];
        int unsigned         list_len [NPRIO];
        logic [PRIO_W-1:0]   lvl_of [NHAND];
        int unsigned         slot_of [NHAND];
        bit                  is_ready [NHAND];
        int unsigned         cap, step, total;
        t_outcome            pending [$];
        int                  errors;

        function new();
            for (int i = 0; i < NPRIO; i++) list_len[i] = 0;
            for (int i = 0; i < NHAND; i++) begin
                lvl_of[i] = 0;
                slot_of[i] = 0;
                is_ready[i] = 0;
            end
            cap = 2;
            step = 1;
            total = 0;
            errors = 0;
        endfunction

        function void append(int h, int lv);
            list_len[lv-1]++;
            lists[lv-1][list_len[lv-1]-1] = HANDLE_W'(h);
            slot_of[h] = list_len[lv-1] - 1;
            lvl_of[h] = PRIO_W'(lv);
            is_ready[h] = 1;
            total++;
        endfunction

        function int take_out(int lv, int s);
            int last;
            int h;
            last = list_len[lv-1] - 1;
            h = int'(lists[lv-1][s]);
            if (s != last) begin
                lists[lv-1][s] = lists[lv-1][last];
                slot_of[lists[lv-1][s]] = s;
            end
            list_len[lv-1] = last;
            is_ready[h] = 0;
            if (total > 0) total--;
            return h;
        endfunction

        function void note_request(t_cmd c, int h, int pr);
            t_outcome r;
            int lv;
            int got;
            bit done;
            if (c == CMD_NONE) return;
            if (c == CMD_PUSH) begin
                if (is_ready[h]) r = {ST_REJECTED, 6'(h), lvl_of[h]};
                else begin
                    if (pr < 1) pr = 1;
                    if (pr > NPRIO) pr = NPRIO;
                    append(h, pr);
                    r = {ST_PUSHED, 6'(h), 4'(pr)};
                end
            end else if (c == CMD_POP) begin
                r = {ST_EMPTY, 6'd0, 4'd0};
                done = 0;
                if (total != 0) begin
                    for (int a = 0; a < PERIOD_VISITS && !done; a++) begin
                        lv = step;
                        got = -1;
                        if (list_len[lv-1] > 0) got = take_out(lv, 0);
                        step++;
                        if (step > cap) begin
                            step = 1;
                            cap++;
                            if (cap > NPRIO) cap = 2;
                        end
                        if (got >= 0) begin
                            r = {ST_POPPED, 6'(got), 4'(lv)};
                            done = 1;
                        end
                    end
                end
            end else begin
                lv = int'(lvl_of[h]);
                if (!is_ready[h] || lv <= 1) r = {ST_NO_CHANGE, 6'(h), 4'(lv)};
                else begin
                    got = take_out(lv, slot_of[h]);
                    append(h, lv - 1);
                    r = {ST_PROMOTED, 6'(h), 4'(lv - 1)};
                end
            end
            pending.push_back(r);
        endfunction

        task automatic check_result(t_outcome got);
            t_outcome exp;
            if (pending.size() == 0) begin
                report_mismatch("result with no request pending");
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status)
                report_mismatch($sformatf("status got %0d expected %0d",
                                          got.status, exp.status));
            if (got.hnd !== exp.hnd)
                report_mismatch($sformatf("out_handle got %0d expected %0d",
                                          got.hnd, exp.hnd));
            if (got.prio !== exp.prio)
                report_mismatch($sformatf("out_priority got %0d expected %0d",
                                          got.prio, exp.prio));
        endtask

        task automatic report_mismatch(string what);
            errors++;
            if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, what);
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    always #1 i_clk = ~i_clk;

    tprs_in_if  req_if ();
    tprs_out_if res_if ();

    triangular_priority_ready_scheduler #(.NUM_PRIORITIES(NPRIO), .NUM_HANDLES(NHAND)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_res(res_if.source)
    );

    sched_scoreboard sb = new();
    int idle_cycles = 0;
    bit stim_done = 0;

    initial begin
        req_if.valid = 0;
        req_if.cmd = CMD_PUSH;
        req_if.handle = 0;
        req_if.priority_req = 0;
        res_if.ready = 0;
    end

    // Receiver stall pattern, sampled result on rising edge.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result({res_if.status, res_if.out_handle, res_if.out_priority});
        if (i_rst_n && ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(negedge i_clk) begin
        if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= ($urandom_range(0, 3) != 0);
            2: res_if.ready <= ($urandom_range(0, 3) == 0);
            default: res_if.ready <= $urandom_range(0, 1);
        endcase
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    int burst_left = 0;

    task automatic send_request(t_cmd c, int h, int pr);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.cmd <= c;
        req_if.handle <= h[5:0];
        req_if.priority_req <= pr[3:0];
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(c, h, pr);
        @(negedge i_clk);
        if (burst_left == 0) req_if.valid <= 1'b0;
    endtask

    task automatic drain();
        if (burst_left != 0) req_if.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_cmd pick_cmd(int pop_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return CMD_NONE;
        if (r < 3 + pop_weight) return CMD_POP;
        if (r < 3 + pop_weight + 20) return CMD_PROMOTE;
        return CMD_PUSH;
    endfunction

    initial begin
        int h;
        int pw;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(CMD_POP, 63, 15);
        send_request(CMD_PROMOTE, 5, 0);
        send_request(CMD_PUSH, 0, 0);
        send_request(CMD_PUSH, 63, 15);
        send_request(CMD_PUSH, 63, 3);
        send_request(CMD_PUSH, 10, 10);
        send_request(CMD_PUSH, 11, 1);
        send_request(CMD_PUSH, 12, 5);
        send_request(CMD_PROMOTE, 11, 0);
        send_request(CMD_PROMOTE, 12, 0);
        send_request(CMD_PROMOTE, 63, 0);
        send_request(CMD_NONE, 21, 7);
        send_request(CMD_PUSH, 42, 9);
        send_request(CMD_PUSH, 43, 9);
        send_request(CMD_PUSH, 44, 9);
        send_request(CMD_PROMOTE, 42, 0);
        for (int i = 0; i < 7; i++) send_request(CMD_POP, 0, 0);
        send_request(CMD_PROMOTE, 10, 0);
        drain();

        for (int i = 0; i < 1750; i++) begin
            if (i % 250 == 0) pw = $urandom_range(10, 50);
            if (i == 900) drain();
            h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
            send_request(pick_cmd(pw), h, $urandom_range(0, 15));
        end
        drain();
        repeat (100) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
